[rtl/scpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpq_pkg: sorted circular priority queue shared definitions
// Types, codes and ring arithmetic used by the queue and its entry store.
// ----------------------------------------------------------------------------
package scpq_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W = 7;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_INSERT,
    S_HEAD
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] seat_number;
    logic [15:0] queue_number;
    logic [15:0] holder_tag;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [15:0]      out_seat;
    logic [15:0]      out_queue_number;
    logic [15:0]      out_holder;
    logic [OCC_W-1:0] occupancy;
    logic             is_empty;
    logic             is_full;
  } res_t;

  typedef struct packed {
    logic [15:0] seat;
    logic [15:0] prio;
    logic [15:0] tag;
  } entry_t;

  // Physical slot of logical position k counted from the head.
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] k);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + (IDX_W+1)'(k);
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

[rtl/scpq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/sorted_circular_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_circular_priority_queue: priority queue kept sorted in a ring RAM
// Holds up to DEPTH entries in ascending priority order, with unique seats.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_i) is taken on a rising edge with start high and busy low.
//   Commands: enqueue, dequeue, peek. Exactly one result per request appears
//   on res_o, flagged by done_o for a single cycle; there is no back-pressure,
//   the receiver must take it in that cycle.
// Sequence (p = insertion position):
//   unused command code, or dequeue/peek on an empty queue: result in the
//   cycle after the request; dequeue/peek otherwise: after one RAM read.
//   enqueue: the single RAM port pair sets the pace. A scan reads one entry a
//   cycle for the duplicate check and the insertion point, then the tail
//   entries from p up move up one slot a cycle, then the new entry is written
//   at p, and the result follows in the next cycle. A duplicate or full
//   reject ends right after the scan.
//   busy is high after an enqueue or a non-empty dequeue/peek is taken, until
//   the result cycle; a new request may be taken in the same cycle that done_o is high.
// Reset: the queue is empty and the head sits at slot 0. The RAM is not
//   cleared; only slots that were written are ever used.
// ----------------------------------------------------------------------------
module sorted_circular_priority_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  scpq_pkg::req_t  req_i,
  output logic            done_o,
  output scpq_pkg::res_t  res_o
);
  import scpq_pkg::*;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // scan / shift bookkeeping
  logic [CNT_W-1:0] k_q, k_d;          // logical position walked
  logic [CNT_W-1:0] p_q, p_d;          // insertion position
  logic [CNT_W-1:0] ridx_q, ridx_d;    // position of the data now on the read port
  logic             rdv_q, rdv_d;      // read data belongs to the scan
  logic             found_q, found_d;  // insertion point located
  logic             dup_q, dup_d;      // seat already present
  logic             pend_q, pend_d;    // shifted entry waiting to be written
  logic [IDX_W-1:0] pdst_q, pdst_d;    // its destination slot

  logic             done_q, done_d;
  res_t             res_q, res_d;
  status_e          status_d;
  entry_t           hold_d;

  // RAM port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  scpq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      p_q     <= '0;
      ridx_q  <= '0;
      rdv_q   <= 1'b0;
      found_q <= 1'b0;
      dup_q   <= 1'b0;
      pend_q  <= 1'b0;
      pdst_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      p_q     <= p_d;
      ridx_q  <= ridx_d;
      rdv_q   <= rdv_d;
      found_q <= found_d;
      dup_q   <= dup_d;
      pend_q  <= pend_d;
      pdst_q  <= pdst_d;
      done_q  <= done_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (done_d) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    p_d       = p_q;
    ridx_d    = ridx_q;
    rdv_d     = 1'b0;
    found_d   = found_q;
    dup_d     = dup_q;
    pend_d    = pend_q;
    pdst_d    = pdst_q;
    done_d    = 1'b0;
    status_d  = ST_OK;
    hold_d    = '0;
    mem_we    = 1'b0;
    mem_waddr = pdst_q;
    mem_wdata = mem_rdata;
    mem_raddr = head_q;

    unique case (state_q)
      S_IDLE: begin
        mem_raddr = head_q;  // head is ready next cycle for dequeue/peek
        if (accept) begin
          req_d = req_i;
          unique case (req_i.cmd)
            CMD_ENQ: begin
              k_d     = '0;
              p_d     = cnt_q;
              found_d = 1'b0;
              dup_d   = 1'b0;
              state_d = S_SCAN;
            end
            CMD_DEQ, CMD_PEEK: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
                done_d   = 1'b1;
              end else begin
                state_d = S_HEAD;
              end
            end
            default: begin
              status_d = ST_OK;
              done_d   = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        mem_raddr = ring_pos(head_q, k_q);
        if (k_q < cnt_q) begin
          rdv_d  = 1'b1;
          ridx_d = k_q;
          k_d    = k_q + 1'b1;
        end
        if (rdv_q) begin
          if (mem_rdata.seat == req_q.seat_number) begin
            dup_d = 1'b1;
          end
          if (!found_q && (mem_rdata.prio > req_q.queue_number)) begin
            found_d = 1'b1;
            p_d     = ridx_q;
          end
        end
        if ((k_q >= cnt_q) && !rdv_q) begin
          priority if (dup_q) begin
            status_d = ST_DUP;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end else if (cnt_q == CNT_W'(DEPTH)) begin
            status_d = ST_FULL;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end else begin
            k_d     = cnt_q;
            pend_d  = 1'b0;
            state_d = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // read slot k-1 while the previous read lands one slot higher
        mem_raddr = ring_pos(head_q, k_q - 1'b1);
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pdst_q;
          mem_wdata = mem_rdata;
        end
        if (k_q > p_q) begin
          pdst_d = ring_pos(head_q, k_q);
          pend_d = 1'b1;
          k_d    = k_q - 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_INSERT;
        end
      end

      S_INSERT: begin
        mem_we         = 1'b1;
        mem_waddr      = ring_pos(head_q, p_q);
        mem_wdata.seat = req_q.seat_number;
        mem_wdata.prio = req_q.queue_number;
        mem_wdata.tag  = req_q.holder_tag;
        cnt_d          = cnt_q + 1'b1;
        status_d       = ST_OK;
        done_d         = 1'b1;
        state_d        = S_IDLE;
      end

      S_HEAD: begin
        hold_d   = mem_rdata;
        status_d = ST_OK;
        done_d   = 1'b1;
        state_d  = S_IDLE;
        if (req_q.cmd == CMD_DEQ) begin
          head_d = ring_pos(head_q, CNT_W'(1));
          cnt_d  = cnt_q - 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.status           = status_d;
    res_d.out_seat         = hold_d.seat;
    res_d.out_queue_number = hold_d.prio;
    res_d.out_holder       = hold_d.tag;
    res_d.occupancy        = OCC_W'(cnt_d);
    res_d.is_empty         = (cnt_d == '0);
    res_d.is_full          = (cnt_d == CNT_W'(DEPTH));
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // ---------------------------------------------------------------- checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result issued while still busy");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.status == ST_FULL || res_o.status == ST_DUP)
      |-> cnt_q == $past(cnt_q))
    else $error("rejected enqueue changed the count");

  a_empty_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.cmd == CMD_DEQ || req_i.cmd == CMD_PEEK) && cnt_q == '0
      |=> done_o && res_o.status == ST_EMPTY)
    else $error("empty dequeue/peek not answered at once");

  a_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_SHIFT || state_q == S_INSERT))
    else $error("RAM write outside shift/insert");

endmodule
